@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/mbps_pkg.sv @@
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mbps_pkg;

	localparam int REG_BYTES = 32;
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W     = 6;
	localparam int ADDR_W    = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT0 = 3'd0,
		REG_PAT1 = 3'd1,
		REG_PAT2 = 3'd2,
		REG_PAT3 = 3'd3,
		REG_CARE = 3'd4,
		REG_LEN  = 3'd5,
		REG_BASE = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic              arm;
		logic [LEN_W-1:0]  len;
		logic [ADDR_W-1:0] addr_base;
	} scan_ctl_t;

endpackage

`default_nettype wire

@@ rtl/mbps_cell.sv @@
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: holds a byte, passes it on, compares it to its
// aligned pattern byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_cell (
	input  wire logic       clk,
	input  wire logic       shift,
	input  wire logic [7:0] byte_in,
	input  wire logic [7:0] pat_byte,
	input  wire logic       care,
	output logic      [7:0] byte_out,
	output logic            hit
);

	logic [7:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	assign hit      = !care || (byte_q == pat_byte);

endmodule

`default_nettype wire

@@ rtl/mbps_align.sv @@
// ----------------------------------------------------------------------------
// mbps_align
// Configuration registers and the length-aligned pattern and care bits
// that the cell row compares against.
// ----------------------------------------------------------------------------
`default_nettype none

module mbps_align #(
	parameter int PATTERN_MAX = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cfg_we,
	input  wire logic [mbps_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [63:0]                             cfg_data,
	output logic      [PATTERN_MAX-1:0][7:0]             aligned_pat_q,
	output logic      [PATTERN_MAX-1:0]                  aligned_care_q,
	output mbps_pkg::scan_ctl_t                          ctl_q
);

	logic [3:0][63:0]                 pat_q;
	logic [31:0]                      care_q;
	logic [mbps_pkg::LEN_W-1:0]       len_q;
	logic [mbps_pkg::ADDR_W-1:0]      base_q;

	logic [PATTERN_MAX-1:0][7:0]      aligned_pat_d;
	logic [PATTERN_MAX-1:0]           aligned_care_d;
	mbps_pkg::scan_ctl_t              ctl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q  <= '0;
			care_q <= '0;
			len_q  <= '0;
			base_q <= '0;
		end else if (cfg_we) begin
			case (mbps_pkg::cfg_reg_t'(cfg_index))
				mbps_pkg::REG_PAT0: pat_q[0] <= cfg_data;
				mbps_pkg::REG_PAT1: pat_q[1] <= cfg_data;
				mbps_pkg::REG_PAT2: pat_q[2] <= cfg_data;
				mbps_pkg::REG_PAT3: pat_q[3] <= cfg_data;
				mbps_pkg::REG_CARE: care_q   <= cfg_data[31:0];
				mbps_pkg::REG_LEN:  len_q    <= cfg_data[mbps_pkg::LEN_W-1:0];
				mbps_pkg::REG_BASE: base_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// window entry j lines up with pattern byte len-1-j
	always_comb begin
		logic [4:0] k;
		k = '0;
		for (int j = 0; j < PATTERN_MAX; j++) begin
			k = 5'(7'(len_q) - 7'(j) - 7'd1);
			aligned_pat_d[j]  = pat_q[k[4:3]][k[2:0]*8 +: 8];
			aligned_care_d[j] = care_q[k] && (7'(j) < 7'(len_q));
		end
	end

	always_comb begin
		ctl_d.arm       = (len_q != '0) && (base_q != '0) &&
		                  (7'(len_q) <= 7'(PATTERN_MAX)) &&
		                  (7'(len_q) <= 7'(mbps_pkg::REG_BYTES));
		ctl_d.len       = len_q;
		ctl_d.addr_base = base_q - mbps_pkg::ADDR_W'(len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_pat_q  <= '0;
			aligned_care_q <= '0;
			ctl_q          <= '0;
		end else begin
			aligned_pat_q  <= aligned_pat_d;
			aligned_care_q <= aligned_care_d;
			ctl_q          <= ctl_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/masked_byte_pattern_scan_unit.sv @@
// a byte's result goes from the compare stage into the output register
// throughput: one byte per cycle; input stalls only while a result waits
//   in the output register and the compare stage is also full
// config writes pass the config and aligned registers before taking effect
// reset: asynchronous, clears config, byte count and handshake state
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit
// Wildcard byte signature scan over a byte stream with a row of window
// cells, a compare stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module masked_byte_pattern_scan_unit #(
	parameter int PATTERN_MAX = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [63:0]                      cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             last,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  found,
	output logic      [63:0]                      match_address
);

	logic [PATTERN_MAX-1:0][7:0]  aligned_pat;
	logic [PATTERN_MAX-1:0]       aligned_care;
	mbps_pkg::scan_ctl_t          ctl;

	logic [PATTERN_MAX-1:0][7:0]  win;
	logic [PATTERN_MAX-1:0]       hit;

	logic        accept;
	logic        valid_s1;
	logic        last_s1;
	logic        s1_adv;
	logic        fire;
	logic [63:0] cnt_q;
	logic [63:0] cnt_base;
	logic        cnt_ok;
	logic        match_reported_q;
	logic        emit_found;
	logic        emit_nf;
	logic        out_valid_q;
	logic        found_q;
	logic [63:0] addr_q;

	assign cfg_ready = 1'b1;

	mbps_align #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_align (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.aligned_pat_q (aligned_pat),
		.aligned_care_q(aligned_care),
		.ctl_q         (ctl)
	);

	assign accept = in_valid && in_ready;

	// window row, newest byte in cell 0
	for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
		mbps_cell u_cell (
			.clk     (clk),
			.shift   (accept),
			.byte_in ((j == 0) ? data_byte : win[(j == 0) ? 0 : j-1]),
			.pat_byte(aligned_pat[j]),
			.care    (aligned_care[j]),
			.byte_out(win[j]),
			.hit     (hit[j])
		);
	end

	// compare stage
	assign cnt_ok     = (|cnt_q[63:mbps_pkg::LEN_W]) ||
	                    (cnt_q[mbps_pkg::LEN_W-1:0] >= ctl.len);
	assign emit_found = valid_s1 && !match_reported_q && ctl.arm && cnt_ok && (&hit);
	assign emit_nf    = valid_s1 && last_s1 && !match_reported_q && !emit_found;
	assign s1_adv     = !out_valid_q || out_ready;
	assign fire       = valid_s1 && s1_adv;
	assign in_ready   = !valid_s1 || s1_adv;
	assign cnt_base   = (fire && last_s1) ? '0 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			last_s1  <= last;
		end
	end

	// saturating byte count of the current region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= (&cnt_base) ? cnt_base : cnt_base + 64'd1;
		end else if (fire && last_s1) begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_reported_q <= 1'b0;
		end else if (fire) begin
			if (last_s1) begin
				match_reported_q <= 1'b0;
			end else if (emit_found) begin
				match_reported_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && (emit_found || emit_nf)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && (emit_found || emit_nf)) begin
			found_q <= emit_found;
			addr_q  <= emit_found ? (ctl.addr_base + cnt_q) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign match_address = addr_q;

	`ASSERT_IMP(a_nf_zero_addr, clk, arst_n, out_valid_q && !found_q, addr_q == '0,
		"not-found beat with nonzero address")
	`ASSERT_NXT(a_match_sticky, clk, arst_n, fire && emit_found && !last_s1,
		match_reported_q, "match not recorded")
	`ASSERT_IMP(a_one_match, clk, arst_n, match_reported_q, !emit_found,
		"second match in one region")
	`ASSERT_IMP(a_cnt_live, clk, arst_n, valid_s1, cnt_q != '0,
		"byte in compare stage with zero count")

endmodule

`default_nettype wire
